// ----- src/alm_pkg.sv -----
// Shared types and constants for the ID allow-list table.
package alm_pkg;

    localparam int ID_W      = 32;
    localparam int TS_W      = 63;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 6;
    localparam int CAP_W     = 6;
    localparam int HOLD_W    = 32;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_W     = 32;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 6'd30;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 32'd4000000;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_OFF = 8'd1;

    // Request codes; any code with the high bit set is a check
    localparam logic [REQ_W-1:0] REQ_REMOVE    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD       = 2'd1;
    localparam int               REQ_CHECK_BIT = 1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED     = 3'd0,
        ST_ALREADY   = 3'd1,
        ST_FULL      = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_PRESENT   = 3'd5,
        ST_ABSENT    = 3'd6
    } alm_status_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [ID_W-1:0]  id_value;
    } alm_cmd_t;

    typedef struct packed {
        logic        valid;
        alm_status_t status;
    } alm_res_t;

endpackage

// ----- src/alm_if.sv -----
// Request and response channel interfaces for the ID allow-list table.
interface alm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] id_value;
    logic [62:0] req_time;

    modport source (output valid, output req_type, output id_value, output req_time,
                    input ready);
    modport sink   (input valid, input req_type, input id_value, input req_time,
                    output ready);
endinterface

interface alm_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        fire;
    logic [5:0]  entry_count;

    modport source (output valid, output status, output fire, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input fire, input entry_count,
                    output ready);
endinterface

// ----- src/alm_gap.sv -----
// Time gap unit: registered timestamp difference and hold-off compare.
module alm_gap (
    input  logic                     clk,
    input  logic                     load,
    input  logic [alm_pkg::TS_W-1:0] ts,
    input  logic [alm_pkg::TS_W-1:0] last_ts,
    input  logic [alm_pkg::HOLD_W-1:0] hold,
    output logic [alm_pkg::TS_W-1:0] ts_held,
    output logic                     over
);
    import alm_pkg::*;

    logic [TS_W:0]   diff;
    logic            neg_reg;
    logic [TS_W-1:0] gap_reg;
    logic [TS_W-1:0] ts_reg;

    assign diff = {1'b0, ts} - {1'b0, last_ts};

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            neg_reg <= diff[TS_W];
            gap_reg <= diff[TS_W-1:0];
            ts_reg  <= ts;
        end
    end

    // a negative gap never fires
    assign over    = !neg_reg && (gap_reg > {{(TS_W-HOLD_W){1'b0}}, hold});
    assign ts_held = ts_reg;

endmodule

// ----- src/alm_engine.sv -----
// Table store and sequencer: linear search, append and compaction over one read port.
module alm_engine #(
    parameter  int DEPTH = 32,
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  alm_pkg::alm_cmd_t cmd,
    input  logic [CW-1:0]     cap,
    input  logic              res_take,
    output logic              idle,
    output alm_pkg::alm_res_t res,
    output logic [CW-1:0]     count
);
    import alm_pkg::*;

    localparam int AW = $clog2(DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_SHIFT, S_DONE} state_t;

    logic [ID_W-1:0] mem [DEPTH];

    state_t          state_reg, state_next;
    alm_cmd_t        cmd_reg, cmd_next;
    alm_status_t     status_reg, status_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   scan_reg, scan_next;
    logic [CW-1:0]   didx_reg, didx_next;
    logic            dv_reg, dv_next;
    logic [ID_W-1:0] rd_data_reg;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [ID_W-1:0] wr_data;
    logic            hit;
    logic            last_data;
    logic [CW-1:0]   didx_inc;
    logic [CW-1:0]   didx_dec;

    assign hit       = dv_reg && (rd_data_reg == cmd_reg.id_value);
    assign last_data = dv_reg && (didx_reg == count_reg - 1'b1);
    assign didx_inc  = didx_reg + 1'b1;
    assign didx_dec  = didx_reg - 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        status_next = status_reg;
        count_next  = count_reg;
        scan_next   = scan_reg;
        didx_next   = scan_reg;
        dv_next     = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = count_reg[AW-1:0];
        wr_data     = cmd_reg.id_value;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    scan_next  = '0;
                    state_next = S_SEARCH;
                end
            end

            S_SEARCH:
            begin
                // issue the next read while comparing the previous one
                if (scan_reg < count_reg)
                begin
                    dv_next   = 1'b1;
                    scan_next = scan_reg + 1'b1;
                end
                if (hit || last_data || (!dv_reg && (scan_reg >= count_reg)))
                begin
                    dv_next    = 1'b0;
                    state_next = S_DONE;
                    if (cmd_reg.req_type[REQ_CHECK_BIT])
                    begin
                        status_next = hit ? ST_PRESENT : ST_ABSENT;
                    end
                    else if (cmd_reg.req_type == REQ_ADD)
                    begin
                        if (hit)
                        begin
                            status_next = ST_ALREADY;
                        end
                        else if (count_reg < cap)
                        begin
                            wr_en       = 1'b1;
                            count_next  = count_reg + 1'b1;
                            status_next = ST_ADDED;
                        end
                        else
                        begin
                            status_next = ST_FULL;
                        end
                    end
                    else if (!hit)
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    else
                    begin
                        status_next = ST_REMOVED;
                        if (didx_inc < count_reg)
                        begin
                            scan_next  = didx_inc;
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
            end

            S_SHIFT:
            begin
                // move each later entry down by one place
                if (scan_reg < count_reg)
                begin
                    dv_next   = 1'b1;
                    scan_next = scan_reg + 1'b1;
                end
                if (dv_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = didx_dec[AW-1:0];
                    wr_data = rd_data_reg;
                end
                if (last_data)
                begin
                    dv_next    = 1'b0;
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            dv_reg     <= 1'b0;
            scan_reg   <= '0;
            didx_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            dv_reg     <= dv_next;
            scan_reg   <= scan_next;
            didx_reg   <= didx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        status_reg <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[scan_reg[AW-1:0]];
    end

    assign idle       = (state_reg == S_IDLE);
    assign res.valid  = (state_reg == S_DONE);
    assign res.status = status_reg;
    assign count      = count_reg;

endmodule

// ----- src/id_allowlist_table_with_holdoff.sv -----
// Top level of the ID allow-list table with check hold-off.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+---------------------------------------
//  req     | in  | valid / ready | req_type[1:0], id_value[31:0],
//          |     |               | req_time[62:0]
//  rsp     | out | valid / ready | status[2:0], fire, entry_count[5:0]
//  cfg     | in  | cfg_we        | cfg_index[7:0], cfg_data[31:0]
//
// The next request is not accepted until this one is through, as set by the single
// registered table read port: the linear search reads the entries up to the match
// (match position plus one, or the count), and a remove then compacts the entries
// that follow the match. Reset clears the count and last check time and restores
// register defaults; table contents are left as they are. A waiting result sits in
// the response register; the sequencer holds its own while rsp stalls.
module id_allowlist_table_with_holdoff #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    alm_req_if.sink                       req,
    alm_rsp_if.source                     rsp,
    input  logic                          cfg_we,
    input  logic [alm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [alm_pkg::CFG_W-1:0]     cfg_data
);
    import alm_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [CAP_W-1:0]    capacity_reg;
    logic [HOLD_W-1:0]   hold_off_reg;
    logic [TS_W-1:0]     last_time_reg;

    logic                out_valid_reg;
    alm_status_t         out_status_reg;
    logic                out_fire_reg;
    logic [COUNT_W-1:0]  out_count_reg;

    logic                eng_idle;
    logic                start;
    logic                take;
    alm_cmd_t            cmd;
    alm_res_t            res;
    logic [CW-1:0]       count;
    logic [CW-1:0]       cap;
    logic [TS_W-1:0]     ts_held;
    logic                gap_over;

    // Accept a new request whenever the sequencer is free
    assign req.ready    = eng_idle;
    assign start        = req.valid && eng_idle;
    assign cmd.req_type = req.req_type;
    assign cmd.id_value = req.id_value;

    // Clamp capacity to the table depth
    always_comb
    begin
        if (32'(capacity_reg) > 32'(TABLE_DEPTH))
        begin
            cap = CW'(TABLE_DEPTH);
        end
        else
        begin
            cap = CW'(capacity_reg);
        end
    end

    // Register writes; drop writes to unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            hold_off_reg <= HOLD_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_CAPACITY)
            begin
                capacity_reg <= cfg_data[CAP_W-1:0];
            end
            else if (cfg_index == CFG_HOLD_OFF)
            begin
                hold_off_reg <= cfg_data[HOLD_W-1:0];
            end
        end
    end

    alm_engine #(
        .DEPTH (TABLE_DEPTH)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .cap      (cap),
        .res_take (take),
        .idle     (eng_idle),
        .res      (res),
        .count    (count)
    );

    // Gap against the last present check, taken at the transfer
    alm_gap u_gap (
        .clk     (clk),
        .load    (start),
        .ts      (req.req_time),
        .last_ts (last_time_reg),
        .hold    (hold_off_reg),
        .ts_held (ts_held),
        .over    (gap_over)
    );

    // Move a finished result into the response register when it is free
    assign take = res.valid && (!out_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            last_time_reg <= '0;
        end
        else
        begin
            if (take)
            begin
                out_valid_reg <= 1'b1;
                if (res.status == ST_PRESENT)
                begin
                    last_time_reg <= ts_held;
                end
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_status_reg <= res.status;
            out_fire_reg   <= (res.status == ST_PRESENT) && gap_over;
            out_count_reg  <= COUNT_W'(count);
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.fire        = out_fire_reg;
    assign rsp.entry_count = out_count_reg;

endmodule
